// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the word speller, used by integer_to_english_words.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, off while reset is asserted.
`define I2EW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds.
`define I2EW_ASSERT_NEVER(lbl, cond, msg) \
  `I2EW_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/i2ew_pkg.sv
// Types, word codes and the microcode program of the integer-to-words speller.
// No dependencies; used by i2ew_bcd, i2ew_seq and integer_to_english_words.
package i2ew_pkg;

  localparam int unsigned ValueWidth = 31;
  localparam int unsigned CodeWidth  = 5;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned PcWidth    = 3;
  localparam int unsigned GroupWidth = 2;

  localparam logic [CodeWidth-1:0] CodeTeenBase = 5'd9;
  localparam logic [CodeWidth-1:0] CodeTensBase = 5'd17;
  localparam logic [CodeWidth-1:0] CodeHundred  = 5'd27;
  localparam logic [CodeWidth-1:0] CodeThousand = 5'd28;
  localparam logic [CodeWidth-1:0] CodeMillion  = 5'd29;
  localparam logic [CodeWidth-1:0] CodeBillion  = 5'd30;
  localparam logic [CodeWidth-1:0] CodeZero     = 5'd31;

  // Program addresses.
  localparam logic [PcWidth-1:0] StepZero   = 3'd0;
  localparam logic [PcWidth-1:0] StepHund   = 3'd1;
  localparam logic [PcWidth-1:0] StepHWord  = 3'd2;
  localparam logic [PcWidth-1:0] StepTeen   = 3'd3;
  localparam logic [PcWidth-1:0] StepTens   = 3'd4;
  localparam logic [PcWidth-1:0] StepUnit   = 3'd5;
  localparam logic [PcWidth-1:0] StepScale  = 3'd6;

  localparam logic [GroupWidth-1:0] TopGroup = 2'd3;

  // Condition under which a step emits a word.
  typedef enum logic [2:0] {
    C_NEVER, C_IN_ZERO, C_H_NZ, C_T_ONE, C_T_GE2, C_UNIT, C_SCALE
  } cond_e;

  // Where the emitted word code comes from.
  typedef enum logic [2:0] {
    SRC_ZERO, SRC_H_M1, SRC_HUNDRED, SRC_TEEN, SRC_TENS, SRC_U_M1, SRC_SCALE
  } src_e;

  // When the emitted word is the final one of the value.
  typedef enum logic [2:0] {
    TL_NONE, TL_ALWAYS, TL_TU_ZERO, TL_U_ZERO, TL_GROUP_END, TL_FINAL
  } tail_e;

  typedef enum logic [1:0] {
    J_NEXT, J_END_IF_ZERO, J_LOOP, J_END
  } jmp_e;

  typedef struct packed {
    cond_e cond;
    src_e  src;
    tail_e tail;
    jmp_e  jmp;
  } ctrl_t;

  typedef struct packed {
    logic                 busy;
    logic                 emit;
    logic [CodeWidth-1:0] code;
    logic                 last;
  } seq_out_t;

  // The program: one pass over a three-digit group, looped from the top group down.
  function automatic ctrl_t ucode_rom(input logic [PcWidth-1:0] pc);
    ctrl_t c;
    case (pc)
      StepZero:  c = '{cond: C_IN_ZERO, src: SRC_ZERO,    tail: TL_FINAL,     jmp: J_END_IF_ZERO};
      StepHund:  c = '{cond: C_H_NZ,    src: SRC_H_M1,    tail: TL_NONE,      jmp: J_NEXT};
      StepHWord: c = '{cond: C_H_NZ,    src: SRC_HUNDRED, tail: TL_TU_ZERO,   jmp: J_NEXT};
      StepTeen:  c = '{cond: C_T_ONE,   src: SRC_TEEN,    tail: TL_ALWAYS,    jmp: J_NEXT};
      StepTens:  c = '{cond: C_T_GE2,   src: SRC_TENS,    tail: TL_U_ZERO,    jmp: J_NEXT};
      StepUnit:  c = '{cond: C_UNIT,    src: SRC_U_M1,    tail: TL_ALWAYS,    jmp: J_NEXT};
      StepScale: c = '{cond: C_SCALE,   src: SRC_SCALE,   tail: TL_GROUP_END, jmp: J_LOOP};
      default:   c = '{cond: C_NEVER,   src: SRC_ZERO,    tail: TL_NONE,      jmp: J_END};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/i2ew_bcd.sv
// Binary to BCD converter, shift-and-add-three, one input bit per cycle.
// Depends on i2ew_pkg.
module i2ew_bcd (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [i2ew_pkg::ValueWidth-1:0]    value_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [i2ew_pkg::BcdWidth-1:0]      digits_o
);
  import i2ew_pkg::*;

  localparam logic [4:0] LastCount = 5'(ValueWidth - 1);

  logic                  busy_q, busy_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [ValueWidth-1:0] shift_q, shift_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [BcdWidth-1:0]   adj;

  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    bcd_d   = bcd_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shift_d = value_i;
      bcd_d   = '0;
    end else if (busy_q) begin
      bcd_d   = {adj[BcdWidth-2:0], shift_q[ValueWidth-1]};
      shift_d = {shift_q[ValueWidth-2:0], 1'b0};
      cnt_d   = cnt_q + 5'd1;
      if (cnt_q == LastCount) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
  end

  assign busy_o   = busy_q;
  assign done_o   = busy_q && (cnt_q == LastCount);
  assign digits_o = bcd_q;

endmodule

// File: rtl/i2ew_seq.sv
// Microcoded word sequencer: program counter, group counter and the digit datapath.
// Depends on i2ew_pkg (program table, word codes, status struct).
module i2ew_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          go_i,
  input  logic [i2ew_pkg::BcdWidth-1:0] digits_i,
  output i2ew_pkg::seq_out_t            seq_o
);
  import i2ew_pkg::*;

  logic                  busy_q, busy_d;
  logic [PcWidth-1:0]    pc_q, pc_d;
  logic [GroupWidth-1:0] grp_q, grp_d;

  ctrl_t                 ctrl;
  logic [3:0]            hd, td, ud;
  logic                  lower_zero, in_zero, grp_nz, cond_w, tail_w, stall;
  logic [CodeWidth-1:0]  scale_code, code_w;

  assign ctrl = ucode_rom(pc_q);

  // Digits of the current group; the billions group has only its units digit.
  always_comb begin
    case (grp_q)
      2'd0: begin
        hd = digits_i[11:8];  td = digits_i[7:4];   ud = digits_i[3:0];
        lower_zero = 1'b1;
        scale_code = CodeZero;
      end
      2'd1: begin
        hd = digits_i[23:20]; td = digits_i[19:16]; ud = digits_i[15:12];
        lower_zero = (digits_i[11:0] == '0);
        scale_code = CodeThousand;
      end
      2'd2: begin
        hd = digits_i[35:32]; td = digits_i[31:28]; ud = digits_i[27:24];
        lower_zero = (digits_i[23:0] == '0);
        scale_code = CodeMillion;
      end
      default: begin
        hd = 4'd0;            td = 4'd0;            ud = digits_i[39:36];
        lower_zero = (digits_i[35:0] == '0);
        scale_code = CodeBillion;
      end
    endcase
  end

  assign in_zero = (digits_i == '0);
  assign grp_nz  = (hd != 4'd0) || (td != 4'd0) || (ud != 4'd0);

  always_comb begin
    case (ctrl.cond)
      C_IN_ZERO: cond_w = in_zero;
      C_H_NZ:    cond_w = (hd != 4'd0);
      C_T_ONE:   cond_w = (td == 4'd1);
      C_T_GE2:   cond_w = (td >= 4'd2);
      C_UNIT:    cond_w = (td != 4'd1) && (ud != 4'd0);
      C_SCALE:   cond_w = (grp_q != 2'd0) && grp_nz;
      default:   cond_w = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.src)
      SRC_H_M1:    code_w = {1'b0, hd} - 5'd1;
      SRC_HUNDRED: code_w = CodeHundred;
      SRC_TEEN:    code_w = CodeTeenBase + {1'b0, ud};
      SRC_TENS:    code_w = CodeTensBase + {1'b0, td};
      SRC_U_M1:    code_w = {1'b0, ud} - 5'd1;
      SRC_SCALE:   code_w = scale_code;
      default:     code_w = CodeZero;
    endcase
  end

  // A word inside a group can only be final in the lowest group, since any
  // higher non-zero group is followed by its scale word.
  always_comb begin
    case (ctrl.tail)
      TL_ALWAYS:    tail_w = (grp_q == 2'd0);
      TL_TU_ZERO:   tail_w = (grp_q == 2'd0) && (td == 4'd0) && (ud == 4'd0);
      TL_U_ZERO:    tail_w = (grp_q == 2'd0) && (ud == 4'd0);
      TL_GROUP_END: tail_w = lower_zero;
      TL_FINAL:     tail_w = 1'b1;
      default:      tail_w = 1'b0;
    endcase
  end

  assign stall = cond_w && !go_i;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    grp_d  = grp_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = StepZero;
      grp_d  = TopGroup;
    end else if (busy_q && !stall) begin
      case (ctrl.jmp)
        J_NEXT: pc_d = pc_q + 3'd1;
        J_END_IF_ZERO: begin
          if (in_zero) begin
            busy_d = 1'b0;
          end else begin
            pc_d = pc_q + 3'd1;
          end
        end
        J_LOOP: begin
          if (grp_q == 2'd0) begin
            busy_d = 1'b0;
          end else begin
            grp_d = grp_q - 2'd1;
            pc_d  = StepHund;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= StepZero;
      grp_q  <= TopGroup;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      grp_q  <= grp_d;
    end
  end

  assign seq_o.busy = busy_q;
  assign seq_o.emit = busy_q && cond_w && go_i;
  assign seq_o.code = code_w;
  assign seq_o.last = tail_w;

endmodule

// File: rtl/integer_to_english_words.sv
// Spells a 31-bit value as English word tokens, highest group first.
// The first word is registered after the binary-to-BCD conversion and the sequencer start.
// One value at a time: a new value is taken only after the sequencer has finished the
// last one. Output stalls hold the sequencer.
// Reset: asynchronous, active low; clears the control state and the output valid.
// Uses i2ew_pkg, i2ew_bcd, i2ew_seq and assert_macros.svh.
`include "assert_macros.svh"

module integer_to_english_words (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [i2ew_pkg::ValueWidth-1:0]     value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [i2ew_pkg::CodeWidth-1:0]      word_code_o,
  output logic                                last_word_o
);
  import i2ew_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_RUN} state_e;

  state_e               state_q;
  logic                 out_valid_q;
  logic [CodeWidth-1:0] word_code_q;
  logic                 last_word_q;

  logic                 in_xfer, bcd_busy, bcd_done, slot_free;
  logic [BcdWidth-1:0]  digits;
  seq_out_t             seq_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  // The output register can take a word if it is empty or drains this cycle.
  assign slot_free  = !out_valid_q || out_ready_i;

  i2ew_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_xfer),
    .value_i  (value_i),
    .busy_o   (bcd_busy),
    .done_o   (bcd_done),
    .digits_o (digits)
  );

  i2ew_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_done),
    .go_i     (slot_free),
    .digits_i (digits),
    .seq_o    (seq_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      word_code_q <= '0;
      last_word_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: if (in_xfer)        state_q <= ST_CONV;
        ST_CONV: if (bcd_done)       state_q <= ST_RUN;
        ST_RUN:  if (!seq_out.busy)  state_q <= ST_IDLE;
        default:                     state_q <= ST_IDLE;
      endcase
      if (seq_out.emit) begin
        out_valid_q <= 1'b1;
        word_code_q <= seq_out.code;
        last_word_q <= seq_out.last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_code_o = word_code_q;
  assign last_word_o = last_word_q;

  `I2EW_ASSERT_NEVER(a_conv_run_overlap, bcd_busy && seq_out.busy, "converter and sequencer both busy")
  `I2EW_ASSERT(a_emit_into_free_slot, seq_out.emit |-> slot_free, "word emitted into a full output register")
  `I2EW_ASSERT(a_idle_quiet, (state_q == ST_IDLE) |-> !seq_out.busy, "sequencer busy while idle")
  `I2EW_ASSERT(a_last_ends_run, (seq_out.emit && seq_out.last) |=> !seq_out.emit, "a word follows the final word")

endmodule
